/* design/knnsf_pkg.sv */
`default_nettype none
package knnsf_pkg;

   // field widths
   localparam int VAL_W  = 10;
   localparam int SRC_W  = 5;
   localparam int TGT_W  = 4;
   localparam int NBR_W  = 6;
   localparam int DIST_W = 25;
   localparam int SUM_W  = 15;
   localparam int SQ_W   = 20;
   localparam int ROOT_W = 13;
   localparam int OUT_W  = 12;

   // register limits from the field definitions
   localparam int SRC_HIGH = 16;
   localparam int TGT_HIGH = 8;
   localparam int NBR_HIGH = 32;

   // operations
   localparam logic [1:0] OP_APPEND  = 2'd0;
   localparam logic [1:0] OP_PREDICT = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   // read address modes
   localparam logic [1:0] MODE_SCAN = 2'd0;
   localparam logic [1:0] MODE_DIAM = 2'd1;
   localparam logic [1:0] MODE_SUM  = 2'd2;
   localparam logic [1:0] MODE_ERR  = 2'd3;

   // square root operand select
   localparam logic [1:0] SQ_SRC = 2'd0;
   localparam logic [1:0] SQ_TGT = 2'd1;
   localparam logic [1:0] SQ_ERR = 2'd2;

   typedef struct packed {
      logic [1:0]       operation;
      logic [VAL_W-1:0] sample_value;
      logic [VAL_W-1:0] query_index;
   } knnsf_req_type;

   typedef struct packed {
      logic             status;
      logic [2:0]       slot;
      logic [VAL_W-1:0] predicted_value;
      logic [VAL_W-1:0] actual_value;
      logic [OUT_W-1:0] source_diameter;
      logic [OUT_W-1:0] target_diameter;
      logic [OUT_W-1:0] prediction_error;
      logic             last;
   } knnsf_rsp_type;

   typedef struct packed {
      logic             append;
      logic             clear;
      logic             q_load;
      logic             rd;
      logic [1:0]       mode;
      logic             acc_clr;
      logic             sum_clr;
      logic             nclr;
      logic             ins;
      logic             div_start;
      logic             pred_wr;
      logic             err_save;
      logic             best_clr;
      logic             best_upd;
      logic             base_load;
      logic             diam_off;
      logic             sqrt_start;
      logic             root_save;
      logic [1:0]       sqrt_sel;
      logic             emit;
      logic             emit_bad;
      logic             last;
      logic [SRC_W-1:0] e;
      logic [VAL_W-1:0] win;
      logic [NBR_W-1:0] idx;
      logic [2:0]       slot;
   } knnsf_cmd_type;

   typedef struct packed {
      logic             bad;
      logic             busy;
      logic             div_busy;
      logic             sqrt_busy;
      logic             out_free;
      logic [VAL_W-1:0] q;
   } knnsf_sts_type;

endpackage
`default_nettype wire

/* design/knnsf_ram.sv */
`default_nettype none
module knnsf_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule
`default_nettype wire

/* design/knnsf_ctrl.sv */
`default_nettype none
module knnsf_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_op,
   input  wire logic [knnsf_pkg::SRC_W-1:0] cfg_s,
   input  wire logic [knnsf_pkg::TGT_W-1:0] cfg_t,
   input  wire logic [knnsf_pkg::NBR_W-1:0] cfg_k,
   input  wire knnsf_pkg::knnsf_sts_type    sts,
   output knnsf_pkg::knnsf_cmd_type         cmd
);
   import knnsf_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CHECK    = 5'd1;
   localparam logic [4:0] S_SCAN     = 5'd2;
   localparam logic [4:0] S_SCAN_DR  = 5'd3;
   localparam logic [4:0] S_SCAN_INS = 5'd4;
   localparam logic [4:0] S_SUM      = 5'd5;
   localparam logic [4:0] S_SUM_DR   = 5'd6;
   localparam logic [4:0] S_DIV_WT   = 5'd7;
   localparam logic [4:0] S_ERR      = 5'd8;
   localparam logic [4:0] S_ERR_DR   = 5'd9;
   localparam logic [4:0] S_BASE     = 5'd10;
   localparam logic [4:0] S_DIAM     = 5'd11;
   localparam logic [4:0] S_DIAM_DR  = 5'd12;
   localparam logic [4:0] S_SQRT     = 5'd13;
   localparam logic [4:0] S_SQRT_WT  = 5'd14;
   localparam logic [4:0] S_EMIT     = 5'd15;
   localparam logic [4:0] S_EMIT_BAD = 5'd16;

   logic [4:0]       state_ff, state_in;
   logic [SRC_W-1:0] e_ff, e_in;
   logic [VAL_W-1:0] win_ff, win_in;
   logic [NBR_W-1:0] i_ff, i_in;
   logic [NBR_W-1:0] j_ff, j_in;
   logic [2:0]       slot_ff, slot_in;
   logic [1:0]       sel_ff, sel_in;

   logic             accept;
   logic [SRC_W-1:0] len_m1;
   logic [TGT_W-1:0] t_m1;
   logic [NBR_W-1:0] k_m1, k_m2;
   logic             slot_last;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign t_m1      = cfg_t - TGT_W'(1);
   assign k_m1      = cfg_k - NBR_W'(1);
   assign k_m2      = cfg_k - NBR_W'(2);
   assign slot_last = ({1'b0, slot_ff} == t_m1);
   // window length: target window in the second diameter pass
   assign len_m1    = (sel_ff == SQ_TGT && state_ff != S_SCAN) ?
                      SRC_W'(t_m1) : cfg_s - SRC_W'(1);

   always_comb begin
      state_in = state_ff;
      e_in     = e_ff;
      win_in   = win_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      slot_in  = slot_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.e    = e_ff;
      cmd.win  = win_ff;
      cmd.idx  = j_ff;
      cmd.slot = slot_ff;
      cmd.sqrt_sel = sel_ff;
      cmd.diam_off = (sel_ff == SQ_TGT);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.append = (req_op == OP_APPEND);
               cmd.clear  = (req_op == OP_CLEAR);
               cmd.q_load = (req_op == OP_PREDICT);
               if (req_op == OP_PREDICT) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (sts.bad) begin
               state_in = S_EMIT_BAD;
            end else begin
               cmd.nclr = 1'b1;
               win_in   = '0;
               e_in     = '0;
               state_in = S_SCAN;
            end
         end
         // score one earlier window, one sample pair a cycle
         S_SCAN: begin
            cmd.rd      = 1'b1;
            cmd.mode    = MODE_SCAN;
            cmd.acc_clr = (e_ff == '0);
            e_in        = e_ff + SRC_W'(1);
            if (e_ff == len_m1) begin
               e_in     = '0;
               state_in = S_SCAN_DR;
            end
         end
         S_SCAN_DR: begin
            if (!sts.busy) begin
               state_in = S_SCAN_INS;
            end
         end
         S_SCAN_INS: begin
            cmd.ins = 1'b1;
            if (win_ff == sts.q - VAL_W'(1)) begin
               slot_in  = '0;
               j_in     = '0;
               state_in = S_SUM;
            end else begin
               win_in   = win_ff + VAL_W'(1);
               state_in = S_SCAN;
            end
         end
         // sum the neighbor samples for this slot
         S_SUM: begin
            cmd.rd      = 1'b1;
            cmd.mode    = MODE_SUM;
            cmd.sum_clr = (j_ff == '0);
            cmd.acc_clr = (j_ff == '0) && (slot_ff == '0);
            j_in        = j_ff + NBR_W'(1);
            if (j_ff == k_m1) begin
               j_in     = '0;
               state_in = S_SUM_DR;
            end
         end
         S_SUM_DR: begin
            if (!sts.busy) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_WT;
            end
         end
         S_DIV_WT: begin
            if (!sts.div_busy) begin
               cmd.pred_wr = 1'b1;
               state_in    = S_ERR;
            end
         end
         S_ERR: begin
            cmd.rd   = 1'b1;
            cmd.mode = MODE_ERR;
            state_in = S_ERR_DR;
         end
         S_ERR_DR: begin
            if (!sts.busy) begin
               if (slot_last) begin
                  cmd.err_save = 1'b1;
                  cmd.best_clr = 1'b1;
                  i_in         = '0;
                  sel_in       = SQ_SRC;
                  state_in     = S_BASE;
               end else begin
                  slot_in  = slot_ff + 3'd1;
                  state_in = S_SUM;
               end
            end
         end
         // pairwise neighbor distances
         S_BASE: begin
            cmd.base_load = 1'b1;
            cmd.idx       = i_ff;
            j_in          = i_ff + NBR_W'(1);
            e_in          = '0;
            state_in      = S_DIAM;
         end
         S_DIAM: begin
            cmd.rd      = 1'b1;
            cmd.mode    = MODE_DIAM;
            cmd.acc_clr = (e_ff == '0);
            e_in        = e_ff + SRC_W'(1);
            if (e_ff == len_m1) begin
               e_in     = '0;
               state_in = S_DIAM_DR;
            end
         end
         S_DIAM_DR: begin
            if (!sts.busy) begin
               cmd.best_upd = 1'b1;
               if (j_ff == k_m1) begin
                  if (i_ff == k_m2) begin
                     state_in = S_SQRT;
                  end else begin
                     i_in     = i_ff + NBR_W'(1);
                     state_in = S_BASE;
                  end
               end else begin
                  j_in     = j_ff + NBR_W'(1);
                  state_in = S_DIAM;
               end
            end
         end
         S_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQRT_WT;
         end
         S_SQRT_WT: begin
            if (!sts.sqrt_busy) begin
               cmd.root_save = 1'b1;
               case (sel_ff)
                  SQ_SRC: begin
                     cmd.best_clr = 1'b1;
                     sel_in       = SQ_TGT;
                     i_in         = '0;
                     state_in     = S_BASE;
                  end
                  SQ_TGT: begin
                     sel_in   = SQ_ERR;
                     state_in = S_SQRT;
                  end
                  default: begin
                     slot_in  = '0;
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = slot_last;
               if (slot_last) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in = slot_ff + 3'd1;
               end
            end
         end
         S_EMIT_BAD: begin
            if (sts.out_free) begin
               cmd.emit_bad = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      e_ff    <= e_in;
      win_ff  <= win_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      slot_ff <= slot_in;
      sel_ff  <= sel_in;
   end
endmodule
`default_nettype wire

/* design/knnsf_dp.sv */
`default_nettype none
module knnsf_dp #(
   parameter int MAX_SAMPLES = 1024,
   parameter int NBR_DEPTH   = 32,
   parameter int TGT_DEPTH   = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire knnsf_pkg::knnsf_req_type    req_data,
   input  wire logic [knnsf_pkg::SRC_W-1:0] cfg_s,
   input  wire logic [knnsf_pkg::TGT_W-1:0] cfg_t,
   input  wire logic [knnsf_pkg::NBR_W-1:0] cfg_k,
   input  wire knnsf_pkg::knnsf_cmd_type    cmd,
   output knnsf_pkg::knnsf_sts_type         sts,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output knnsf_pkg::knnsf_rsp_type         rsp_data
);
   import knnsf_pkg::*;

   localparam int AW  = $clog2(MAX_SAMPLES);
   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int XW  = ((CW > 11) ? CW : 11) + 1;
   localparam int NIW = $clog2(NBR_DEPTH);
   localparam int TIW = $clog2(TGT_DEPTH);
   localparam logic [TGT_W-1:0] T_ROOT2 = TGT_W'(4);  // floor sqrt(t) is 2 from here
   localparam logic [ROOT_W-1:0] SAT_MAX = ROOT_W'(4095);

   logic [CW-1:0]     count_ff, count_in;
   logic [VAL_W-1:0]  q_ff, q_in;
   logic              p1_ff, p1_in;
   logic [1:0]        p1_mode_ff, p1_mode_in;
   logic              p2_ff, p2_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [DIST_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DIST_W-1:0] err_ff, err_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [VAL_W-1:0]  base_ff, base_in;
   logic [NBR_W-1:0]  nfill_ff, nfill_in;
   logic [DIST_W-1:0] nd_ff [NBR_DEPTH];
   logic [DIST_W-1:0] nd_in [NBR_DEPTH];
   logic [VAL_W-1:0]  ns_ff [NBR_DEPTH];
   logic [VAL_W-1:0]  ns_in [NBR_DEPTH];
   logic [VAL_W-1:0]  pred_ff [TGT_DEPTH];
   logic [VAL_W-1:0]  pred_in [TGT_DEPTH];
   logic [VAL_W-1:0]  act_ff [TGT_DEPTH];
   logic [VAL_W-1:0]  act_in [TGT_DEPTH];
   logic [5:0]        drem_ff, drem_in;
   logic [SUM_W-1:0]  dquo_ff, dquo_in;
   logic [3:0]        dcnt_ff, dcnt_in;
   logic              dbusy_ff, dbusy_in;
   logic [2*ROOT_W-1:0] sx_ff, sx_in;
   logic [15:0]       sr_ff, sr_in;
   logic [ROOT_W-1:0] sq_root_ff, sq_root_in;
   logic [3:0]        scnt_ff, scnt_in;
   logic              sbusy_ff, sbusy_in;
   logic [OUT_W-1:0]  sd_ff, sd_in;
   logic [OUT_W-1:0]  td_ff, td_in;
   logic [OUT_W-1:0]  er_ff, er_in;
   logic              rsp_valid_ff, rsp_valid_in;
   knnsf_rsp_type     rsp_data_ff, rsp_data_in;

   logic [XW-1:0]     ta, tb, off_x, s_x, q_x, slot_x;
   logic [XW-1:0]     addr_a, addr_b;
   logic [VAL_W-1:0]  nsel;
   logic [VAL_W-1:0]  rd_a, rd_b, op_a;
   logic              wr_en;
   logic signed [VAL_W:0]   diff;
   logic signed [2*VAL_W+1:0] prod;
   logic [NBR_W-1:0]  pos_top;
   logic              full, ins_ok;
   logic [NBR_DEPTH-1:0] gt;
   logic [6:0]        drn;
   logic [15:0]       srn, strial;
   logic [ROOT_W-1:0] err_root;
   logic [TIW-1:0]    sidx;

   assign sidx  = cmd.slot[TIW-1:0];
   assign nsel  = ns_ff[cmd.idx[NIW-1:0]];
   assign s_x   = XW'(cfg_s);
   assign q_x   = XW'(q_ff);
   assign slot_x = XW'(cmd.slot);
   assign off_x = cmd.diam_off ? s_x : '0;
   assign wr_en = cmd.append && (count_ff < CW'(MAX_SAMPLES));

   // read address bases per mode
   always_comb begin
      case (cmd.mode)
         MODE_SCAN: begin
            ta = q_x;
            tb = XW'(cmd.win);
         end
         MODE_DIAM: begin
            ta = XW'(base_ff) + off_x;
            tb = XW'(nsel) + off_x;
         end
         MODE_SUM: begin
            ta = XW'(nsel) + s_x + slot_x;
            tb = '0;
         end
         default: begin
            ta = '0;
            tb = q_x + s_x + slot_x;
         end
      endcase
   end

   assign addr_a = ta + XW'(cmd.e);
   assign addr_b = tb + XW'(cmd.e);

   knnsf_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_SAMPLES)
   ) u_samples (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_data   (req_data.sample_value),
      .rd_addr_a (addr_a[AW-1:0]),
      .rd_data_a (rd_a),
      .rd_addr_b (addr_b[AW-1:0]),
      .rd_data_b (rd_b)
   );

   // difference and square on returned sample pair
   assign op_a = (p1_mode_ff == MODE_ERR) ? pred_ff[sidx] : rd_a;
   assign diff = $signed({1'b0, op_a}) - $signed({1'b0, rd_b});
   assign prod = diff * diff;

   // neighbor insertion: place after all entries not greater than the new one
   assign full    = (nfill_ff >= cfg_k);
   assign pos_top = full ? cfg_k - NBR_W'(1) : nfill_ff;
   assign ins_ok  = !full || (acc_ff < nd_ff[pos_top[NIW-1:0]]);
   always_comb begin
      for (int j = 0; j < NBR_DEPTH; j++) begin
         gt[j] = (NBR_W'(j) < pos_top) && (nd_ff[j] > acc_ff);
      end
   end

   // divider and square root step terms
   assign drn    = {drem_ff, dquo_ff[SUM_W-1]};
   assign srn    = {sr_ff[13:0], sx_ff[2*ROOT_W-1 -: 2]};
   assign strial = {1'b0, sq_root_ff, 2'b01};
   assign err_root = (cfg_t >= T_ROOT2) ? (sq_root_ff >> 1) : sq_root_ff;

   always_comb begin
      count_in   = count_ff;
      q_in       = q_ff;
      p1_in      = cmd.rd;
      p1_mode_in = cmd.mode;
      p2_in      = p1_ff && (p1_mode_ff != MODE_SUM);
      sq_in      = p1_ff ? prod[SQ_W-1:0] : sq_ff;
      acc_in     = acc_ff;
      sum_in     = sum_ff;
      err_in     = err_ff;
      best_in    = best_ff;
      base_in    = base_ff;
      nfill_in   = nfill_ff;
      nd_in      = nd_ff;
      ns_in      = ns_ff;
      pred_in    = pred_ff;
      act_in     = act_ff;
      drem_in    = drem_ff;
      dquo_in    = dquo_ff;
      dcnt_in    = dcnt_ff;
      dbusy_in   = dbusy_ff;
      sx_in      = sx_ff;
      sr_in      = sr_ff;
      sq_root_in = sq_root_ff;
      scnt_in    = scnt_ff;
      sbusy_in   = sbusy_ff;
      sd_in      = sd_ff;
      td_in      = td_ff;
      er_in      = er_ff;

      // history count
      if (cmd.clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.q_load) begin
         q_in = req_data.query_index;
      end

      // accumulators
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (p2_ff) begin
         acc_in = acc_ff + DIST_W'(sq_ff);
      end
      if (cmd.sum_clr) begin
         sum_in = '0;
      end else if (p1_ff && p1_mode_ff == MODE_SUM) begin
         sum_in = sum_ff + SUM_W'(rd_a);
      end
      if (p1_ff && p1_mode_ff == MODE_ERR) begin
         act_in[sidx] = rd_b;
      end
      if (cmd.err_save) begin
         err_in = acc_ff;
      end
      if (cmd.best_clr) begin
         best_in = '0;
      end else if (cmd.best_upd && acc_ff > best_ff) begin
         best_in = acc_ff;
      end
      if (cmd.base_load) begin
         base_in = nsel;
      end

      // neighbor table
      if (cmd.nclr) begin
         nfill_in = '0;
      end else if (cmd.ins && ins_ok) begin
         if (!full) begin
            nfill_in = nfill_ff + NBR_W'(1);
         end
         for (int j = 0; j < NBR_DEPTH; j++) begin
            if (NBR_W'(j) <= pos_top) begin
               if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
                  nd_in[j] = nd_ff[(j > 0) ? j - 1 : 0];
                  ns_in[j] = ns_ff[(j > 0) ? j - 1 : 0];
               end else if (NBR_W'(j) == pos_top || gt[j]) begin
                  nd_in[j] = acc_ff;
                  ns_in[j] = cmd.win;
               end
            end
         end
      end

      // restoring divider, one quotient bit a cycle
      if (cmd.div_start) begin
         drem_in  = '0;
         dquo_in  = sum_ff;
         dcnt_in  = '0;
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         if (drn >= {1'b0, cfg_k}) begin
            drem_in = 6'(drn - {1'b0, cfg_k});
            dquo_in = {dquo_ff[SUM_W-2:0], 1'b1};
         end else begin
            drem_in = drn[5:0];
            dquo_in = {dquo_ff[SUM_W-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 4'd1;
         if (dcnt_ff == 4'(SUM_W - 1)) begin
            dbusy_in = 1'b0;
         end
      end
      if (cmd.pred_wr) begin
         pred_in[sidx] = dquo_ff[VAL_W-1:0];
      end

      // square root, two radicand bits a cycle
      if (cmd.sqrt_start) begin
         sx_in      = {1'b0, (cmd.sqrt_sel == SQ_ERR) ? err_ff : best_ff};
         sr_in      = '0;
         sq_root_in = '0;
         scnt_in    = '0;
         sbusy_in   = 1'b1;
      end else if (sbusy_ff) begin
         if (srn >= strial) begin
            sr_in      = srn - strial;
            sq_root_in = {sq_root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            sr_in      = srn;
            sq_root_in = {sq_root_ff[ROOT_W-2:0], 1'b0};
         end
         sx_in   = {sx_ff[2*ROOT_W-3:0], 2'b00};
         scnt_in = scnt_ff + 4'd1;
         if (scnt_ff == 4'(ROOT_W - 1)) begin
            sbusy_in = 1'b0;
         end
      end
      if (cmd.root_save) begin
         case (cmd.sqrt_sel)
            SQ_SRC: sd_in = (sq_root_ff > SAT_MAX) ? OUT_W'(SAT_MAX) : sq_root_ff[OUT_W-1:0];
            SQ_TGT: td_in = (sq_root_ff > SAT_MAX) ? OUT_W'(SAT_MAX) : sq_root_ff[OUT_W-1:0];
            default: er_in = (err_root > SAT_MAX) ? OUT_W'(SAT_MAX) : err_root[OUT_W-1:0];
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit_bad) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in        = '0;
         rsp_data_in.status = 1'b1;
         rsp_data_in.last   = 1'b1;
      end else if (cmd.emit) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.status           = 1'b0;
         rsp_data_in.slot             = cmd.slot;
         rsp_data_in.predicted_value  = pred_ff[sidx];
         rsp_data_in.actual_value     = act_ff[sidx];
         rsp_data_in.source_diameter  = sd_ff;
         rsp_data_in.target_diameter  = td_ff;
         rsp_data_in.prediction_error = er_ff;
         rsp_data_in.last             = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         dbusy_ff     <= 1'b0;
         sbusy_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         dbusy_ff     <= dbusy_in;
         sbusy_ff     <= sbusy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff        <= q_in;
      p1_mode_ff  <= p1_mode_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      err_ff      <= err_in;
      best_ff     <= best_in;
      base_ff     <= base_in;
      nfill_ff    <= nfill_in;
      nd_ff       <= nd_in;
      ns_ff       <= ns_in;
      pred_ff     <= pred_in;
      act_ff      <= act_in;
      drem_ff     <= drem_in;
      dquo_ff     <= dquo_in;
      dcnt_ff     <= dcnt_in;
      sx_ff       <= sx_in;
      sr_ff       <= sr_in;
      sq_root_ff  <= sq_root_in;
      scnt_ff     <= scnt_in;
      sd_ff       <= sd_in;
      td_ff       <= td_in;
      er_ff       <= er_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status to controller
   always_comb begin
      sts           = '0;
      sts.bad       = (q_ff < VAL_W'(cfg_k)) ||
                      ((q_x + s_x + XW'(cfg_t)) > XW'(count_ff));
      sts.busy      = p1_ff || p2_ff;
      sts.div_busy  = dbusy_ff;
      sts.sqrt_busy = sbusy_ff;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
      sts.q         = q_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

/* design/knn_series_forecaster.sv */
`default_nettype none
// Channel   Ports                               Direction
// input     req_valid, req_stall, req_data      items in: append, predict, clear
// result    rsp_valid, rsp_stall, rsp_data      one item per predicted slot, or one error item
// config    psel, penable, pwrite, paddr,       register write and read
//           pwdata, prdata, pready
//
// Append and clear are taken in the idle state. A predict item holds the
// input through window scoring (one sample pair a cycle through the single
// dual-read sample RAM, waiting between windows for the pipeline to drain),
// the means for each target slot, about neighbor_count^2/2 pairs of window
// scans for each diameter, and three square roots. Synchronous reset clears
// the sample count and control state; the sample RAM is not cleared. A
// stalled result holds the controller before the next result item.
module knn_series_forecaster #(
   parameter int MAX_SAMPLES   = 1024,
   parameter int MAX_SOURCE    = 16,
   parameter int MAX_TARGET    = 8,
   parameter int MAX_NEIGHBORS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire knnsf_pkg::knnsf_req_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output knnsf_pkg::knnsf_rsp_type      rsp_data,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [3:0]               paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import knnsf_pkg::*;

   localparam int SRC_MAX = (MAX_SOURCE < SRC_HIGH) ? MAX_SOURCE : SRC_HIGH;
   localparam int TGT_MAX = (MAX_TARGET < TGT_HIGH) ? MAX_TARGET : TGT_HIGH;
   localparam int NBR_MAX = (MAX_NEIGHBORS < NBR_HIGH) ? MAX_NEIGHBORS : NBR_HIGH;

   localparam logic [1:0] REG_SOURCE_LEN     = 2'd0;
   localparam logic [1:0] REG_TARGET_LEN     = 2'd1;
   localparam logic [1:0] REG_NEIGHBOR_COUNT = 2'd2;

   logic [SRC_W-1:0] src_len_ff, src_len_in;
   logic [TGT_W-1:0] tgt_len_ff, tgt_len_in;
   logic [NBR_W-1:0] nbr_cnt_ff, nbr_cnt_in;
   logic             wr;
   logic [SRC_W-1:0] w_src;
   logic [TGT_W-1:0] w_tgt;
   logic [NBR_W-1:0] w_nbr;
   knnsf_cmd_type    cmd;
   knnsf_sts_type    sts;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign w_src  = pwdata[SRC_W-1:0];
   assign w_tgt  = pwdata[TGT_W-1:0];
   assign w_nbr  = pwdata[NBR_W-1:0];

   // register writes, saturated to the legal range
   always_comb begin
      src_len_in = src_len_ff;
      tgt_len_in = tgt_len_ff;
      nbr_cnt_in = nbr_cnt_ff;
      if (wr) begin
         case (paddr[3:2])
            REG_SOURCE_LEN: begin
               src_len_in = (w_src < SRC_W'(2)) ? SRC_W'(2) :
                            (w_src > SRC_W'(SRC_MAX)) ? SRC_W'(SRC_MAX) : w_src;
            end
            REG_TARGET_LEN: begin
               tgt_len_in = (w_tgt < TGT_W'(2)) ? TGT_W'(2) :
                            (w_tgt > TGT_W'(TGT_MAX)) ? TGT_W'(TGT_MAX) : w_tgt;
            end
            REG_NEIGHBOR_COUNT: begin
               nbr_cnt_in = (w_nbr < NBR_W'(2)) ? NBR_W'(2) :
                            (w_nbr > NBR_W'(NBR_MAX)) ? NBR_W'(NBR_MAX) : w_nbr;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_len_ff <= (SRC_MAX < 12) ? SRC_W'(SRC_MAX) : SRC_W'(12);
         tgt_len_ff <= (TGT_MAX < 6) ? TGT_W'(TGT_MAX) : TGT_W'(6);
         nbr_cnt_ff <= (NBR_MAX < 20) ? NBR_W'(NBR_MAX) : NBR_W'(20);
      end else begin
         src_len_ff <= src_len_in;
         tgt_len_ff <= tgt_len_in;
         nbr_cnt_ff <= nbr_cnt_in;
      end
   end

   // register read
   always_comb begin
      case (paddr[3:2])
         REG_SOURCE_LEN:     prdata = 32'(src_len_ff);
         REG_TARGET_LEN:     prdata = 32'(tgt_len_ff);
         REG_NEIGHBOR_COUNT: prdata = 32'(nbr_cnt_ff);
         default:            prdata = '0;
      endcase
   end

   knnsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_data.operation),
      .cfg_s     (src_len_ff),
      .cfg_t     (tgt_len_ff),
      .cfg_k     (nbr_cnt_ff),
      .sts       (sts),
      .cmd       (cmd)
   );

   knnsf_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .NBR_DEPTH   (NBR_MAX),
      .TGT_DEPTH   (TGT_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg_s     (src_len_ff),
      .cfg_t     (tgt_len_ff),
      .cfg_k     (nbr_cnt_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire
